FILE: src/qpm_pkg.sv
package qpm_pkg;

  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned QUO_W       = 62;
  localparam int unsigned DEN_W       = 33;
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned TOUT_W      = 48;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned LO_W        = 31;
  localparam int unsigned HI_W        = QUO_W - LO_W;
  localparam int unsigned PROD_W      = MAG_W + LO_W;
  localparam int unsigned FULL_W      = PROD_W + LO_W;
  localparam int unsigned ROUND_POS   = 45;
  localparam int unsigned SHIFT       = 46;
  localparam int unsigned ENT_W       = 17;
  localparam logic [15:0] ONE_Q14     = 16'd16384;
  localparam logic [NUM_ENTRIES-1:0] IS_DIAG = 9'b100010001;

  // payload that rides along the divider chain
  typedef struct packed {
    logic                             nz;
    logic [NUM_ENTRIES-1:0]           neg;
    logic [NUM_ENTRIES-1:0][MAG_W-1:0] mag;
    logic [2:0][TOUT_W-1:0]           t;
  } pl_t;

  // divider working state
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

FILE: src/qpm_div_cell.sv
module qpm_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         bit_i,
  input  logic         valid_i,
  input  qpm_pkg::div_t div_i,
  input  qpm_pkg::pl_t  pl_i,
  output logic         valid_o,
  output qpm_pkg::div_t div_o,
  output qpm_pkg::pl_t  pl_o
);
  import qpm_pkg::*;

  logic [DEN_W:0] sh;
  logic [DEN_W:0] diff;
  logic           ge;
  div_t           div_d;
  logic           valid_q;
  div_t           div_q;
  pl_t            pl_q;

  // one restoring step: shift in a dividend bit, subtract when it fits
  always_comb begin
    sh    = {div_i.rem, bit_i};
    diff  = sh - {1'b0, div_i.den};
    ge    = (sh >= {1'b0, div_i.den});
    div_d.den = div_i.den;
    div_d.rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    div_d.quo = {div_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
      pl_q  <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign pl_o    = pl_q;

endmodule

FILE: src/qpm_front.sv
module qpm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [qpm_pkg::SCALE_W-1:0]  scale_i,
  input  logic signed [31:0]           tx_i,
  input  logic signed [31:0]           ty_i,
  input  logic signed [31:0]           tz_i,
  input  logic signed [15:0]           w_i,
  input  logic signed [15:0]           x_i,
  input  logic signed [15:0]           y_i,
  input  logic signed [15:0]           z_i,
  output logic                         valid_o,
  output qpm_pkg::div_t                div_o,
  output qpm_pkg::pl_t                 pl_o
);
  import qpm_pkg::*;

  // products stage
  logic               v1_q;
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [31:0] t1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      zz_q <= z_i * z_i;
      ww_q <= w_i * w_i;
      xy_q <= x_i * y_i;
      xz_q <= x_i * z_i;
      yz_q <= y_i * z_i;
      wx_q <= w_i * x_i;
      wy_q <= w_i * y_i;
      wz_q <= w_i * z_i;
      t1_q[0] <= tx_i;
      t1_q[1] <= ty_i;
      t1_q[2] <= tz_i;
    end
  end

  // sums, magnitudes and translation scaling
  logic signed [32:0] p_d [NUM_ENTRIES];
  logic [DEN_W-1:0]   n_d;
  div_t               div_d;
  pl_t                pl_d;
  logic signed [56:0] tp;

  always_comb begin
    n_d = DEN_W'($unsigned(xx_q)) + DEN_W'($unsigned(yy_q))
        + DEN_W'($unsigned(zz_q)) + DEN_W'($unsigned(ww_q));
    p_d[0] = 33'(yy_q) + 33'(zz_q);
    p_d[1] = 33'(xy_q) - 33'(wz_q);
    p_d[2] = 33'(xz_q) + 33'(wy_q);
    p_d[3] = 33'(xy_q) + 33'(wz_q);
    p_d[4] = 33'(xx_q) + 33'(zz_q);
    p_d[5] = 33'(yz_q) - 33'(wx_q);
    p_d[6] = 33'(xz_q) - 33'(wy_q);
    p_d[7] = 33'(yz_q) + 33'(wx_q);
    p_d[8] = 33'(xx_q) + 33'(yy_q);
    pl_d.nz = (n_d != '0);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      pl_d.neg[i] = p_d[i][32];
      pl_d.mag[i] = p_d[i][32] ? MAG_W'(-p_d[i]) : MAG_W'(p_d[i]);
    end
    for (int j = 0; j < 3; j++) begin
      tp = t1_q[j] * $signed({1'b0, scale_i});
      pl_d.t[j] = TOUT_W'(tp >>> 16);
    end
    div_d.den = n_d;
    div_d.rem = '0;
    div_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o <= div_d;
      pl_o  <= pl_d;
    end
  end

endmodule

FILE: src/qpm_back.sv
module qpm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qpm_pkg::QUO_W-1:0]   recip_i,
  input  qpm_pkg::pl_t                pl_i,
  output logic                        valid_o,
  output logic [qpm_pkg::NUM_ENTRIES-1:0][15:0] r_o,
  output logic [2:0][qpm_pkg::TOUT_W-1:0]       t_o
);
  import qpm_pkg::*;

  // partial products of magnitude and reciprocal
  logic                   vm_q;
  logic [PROD_W-1:0]      plo_q [NUM_ENTRIES];
  logic [PROD_W-1:0]      phi_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] neg_q;
  logic [2:0][TOUT_W-1:0] tm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vm_q    <= valid_i & pl_i.nz;
      valid_o <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        plo_q[i] <= PROD_W'(pl_i.mag[i]) * PROD_W'(recip_i[LO_W-1:0]);
        phi_q[i] <= PROD_W'(pl_i.mag[i]) * PROD_W'(recip_i[QUO_W-1:LO_W]);
      end
      neg_q <= pl_i.neg;
      tm_q  <= pl_i.t;
    end
  end

  // combine, round half away from zero, apply sign or diagonal offset
  logic [FULL_W-1:0] full;
  logic [ENT_W-1:0]  v;
  logic [15:0]       r_d [NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      full = {phi_q[i], {LO_W{1'b0}}} + FULL_W'(plo_q[i])
           + (FULL_W'(1) << ROUND_POS);
      v = full[SHIFT+ENT_W-1:SHIFT];
      if (IS_DIAG[i]) begin
        r_d[i] = ONE_Q14 - v[15:0];
      end else if (neg_q[i]) begin
        r_d[i] = 16'(-v);
      end else begin
        r_d[i] = v[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        r_o[i] <= r_d[i];
      end
      t_o <= tm_q;
    end
  end

endmodule

FILE: src/quaternion_pose_to_matrix.sv
// quaternion pose to rotation matrix and scaled translation
//
// input channel: valid_i / stall_o with the translation and quaternion fields;
// a transfer happens on a rising edge with valid_i high and stall_o low.
// output channel: valid_o / stall_i with the nine matrix entries and the
// scaled translation; a transfer happens with valid_o high and stall_i low.
// scale_factor_we_i writes scale_factor_i (Q8.16) into the scale register;
// write it only while no pose is in flight.
//
// from input transfer to result, a pose passes one input register, a products
// register and a sums register, 62 cells of the restoring reciprocal chain
// (one quotient bit per cell), a partial-product register and the rounded output
// register. throughput is one pose per cycle while no result is stalled;
// the divider chain is fully pipelined.
// an all-zero quaternion produces no output.
// reset clears all valid flags and sets the scale to 1.0. when the receiver
// stalls a waiting result, the whole pipeline holds and stall_o rises.
module quaternion_pose_to_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scale_factor_we_i,
  input  logic [23:0]         scale_factor_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic signed [31:0]  trans_x_i,
  input  logic signed [31:0]  trans_y_i,
  input  logic signed [31:0]  trans_z_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [15:0]  r00_o,
  output logic signed [15:0]  r01_o,
  output logic signed [15:0]  r02_o,
  output logic signed [15:0]  r10_o,
  output logic signed [15:0]  r11_o,
  output logic signed [15:0]  r12_o,
  output logic signed [15:0]  r20_o,
  output logic signed [15:0]  r21_o,
  output logic signed [15:0]  r22_o,
  output logic signed [47:0]  out_tx_o,
  output logic signed [47:0]  out_ty_o,
  output logic signed [47:0]  out_tz_o
);
  import qpm_pkg::*;

  logic [SCALE_W-1:0] scale_q;
  logic               en;

  // scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd65536;
    end else if (scale_factor_we_i) begin
      scale_q <= scale_factor_i;
    end
  end

  // global advance: hold every pipeline register while a stalled result waits
  assign en      = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  // input register
  logic               vi_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic signed [15:0] w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else if (en) begin
      vi_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= trans_x_i;
      ty_q <= trans_y_i;
      tz_q <= trans_z_i;
      w_q  <= quat_w_i;
      x_q  <= quat_x_i;
      y_q  <= quat_y_i;
      z_q  <= quat_z_i;
    end
  end

  // products and sums
  logic chain_v [QUO_W+1];
  div_t chain_d [QUO_W+1];
  pl_t  chain_p [QUO_W+1];

  qpm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vi_q),
    .scale_i (scale_q),
    .tx_i    (tx_q),
    .ty_i    (ty_q),
    .tz_i    (tz_q),
    .w_i     (w_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .valid_o (chain_v[0]),
    .div_o   (chain_d[0]),
    .pl_o    (chain_p[0])
  );

  // reciprocal chain: dividend is a single one at the top bit
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    qpm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (k == 0),
      .valid_i (chain_v[k]),
      .div_i   (chain_d[k]),
      .pl_i    (chain_p[k]),
      .valid_o (chain_v[k+1]),
      .div_o   (chain_d[k+1]),
      .pl_o    (chain_p[k+1])
    );
  end

  // scaling, rounding and output register
  logic [NUM_ENTRIES-1:0][15:0] r;
  logic [2:0][TOUT_W-1:0]       t;

  qpm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[QUO_W]),
    .recip_i (chain_d[QUO_W].quo),
    .pl_i    (chain_p[QUO_W]),
    .valid_o (valid_o),
    .r_o     (r),
    .t_o     (t)
  );

  assign r00_o    = r[0];
  assign r01_o    = r[1];
  assign r02_o    = r[2];
  assign r10_o    = r[3];
  assign r11_o    = r[4];
  assign r12_o    = r[5];
  assign r20_o    = r[6];
  assign r21_o    = r[7];
  assign r22_o    = r[8];
  assign out_tx_o = t[0];
  assign out_ty_o = t[1];
  assign out_tz_o = t[2];

endmodule

FILE: test/tb_quaternion_pose_to_matrix.sv
`timescale 1ns / 1ps

module tb_quaternion_pose_to_matrix;

  localparam int unsigned LATENCY    = 68;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] tx, ty, tz;
    logic signed [15:0] w, x, y, z;
  } pose_t;

  typedef struct packed {
    logic signed [8:0][15:0] r;
    logic signed [2:0][47:0] t;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic scale_factor_we_i = 1'b0;
  logic [23:0] scale_factor_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [31:0] trans_x_i = '0, trans_y_i = '0, trans_z_i = '0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;
  logic signed [47:0] out_tx_o, out_ty_o, out_tz_o;

  frame_t expected_frames[$];
  logic [23:0] scale_reg;
  int errors = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;

  quaternion_pose_to_matrix dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // rounded magnitude product, half away from zero
  function automatic longint unsigned round_mag(longint unsigned mag,
                                                longint unsigned recip);
    logic [127:0] prod;
    prod = 128'(mag) * 128'(recip) + (128'd1 << 45);
    return 64'(prod >> 46);
  endfunction

  function automatic logic [15:0] off_entry(longint p, longint unsigned recip);
    longint r;
    r = longint'(round_mag((p < 0) ? -p : p, recip));
    return 16'((p < 0) ? -r : r);
  endfunction

  function automatic logic [15:0] diag_entry(longint d, longint unsigned recip);
    return 16'(64'sd16384 - longint'(round_mag(d, recip)));
  endfunction

  function automatic logic [47:0] scale_trans(logic signed [31:0] t);
    longint p;
    p = longint'(t) * longint'({40'd0, scale_reg});
    return 48'(p >>> 16);
  endfunction

  // predicted matrix and translation for one pose
  function automatic bit pose_to_frame(pose_t p, output frame_t f);
    longint w, x, y, z, n;
    longint unsigned recip;
    w = p.w; x = p.x; y = p.y; z = p.z;
    n = w*w + x*x + y*y + z*z;
    f = '0;
    if (n == 0) return 1'b0;
    recip = (64'd1 << 61) / n;
    f.r[8] = diag_entry(y*y + z*z, recip);
    f.r[7] = off_entry(x*y - w*z, recip);
    f.r[6] = off_entry(x*z + w*y, recip);
    f.r[5] = off_entry(x*y + w*z, recip);
    f.r[4] = diag_entry(x*x + z*z, recip);
    f.r[3] = off_entry(y*z - w*x, recip);
    f.r[2] = off_entry(x*z - w*y, recip);
    f.r[1] = off_entry(y*z + w*x, recip);
    f.r[0] = diag_entry(x*x + y*y, recip);
    f.t[2] = scale_trans(p.tx);
    f.t[1] = scale_trans(p.ty);
    f.t[0] = scale_trans(p.tz);
    return 1'b1;
  endfunction

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (!stall_enable) stall_i <= 1'b0;
    else case ($urandom_range(0, 3))
      0: stall_i <= 1'b1;
      1: stall_i <= ($urandom_range(0, 1) == 1);
      default: stall_i <= 1'b0;
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    frame_t got, want;
    if (rst_ni && valid_o && !stall_i) begin
      got.r = {r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      got.t = {out_tx_o, out_ty_o, out_tz_o};
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result transfer r=%h t=%h", $time, got.r, got.t);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.r[i] !== want.r[i]) begin
            $display("%0t: r%0d%0d expected %0d actual %0d", $time, (8-i)/3, (8-i)%3,
                     want.r[i], got.r[i]);
            errors++;
          end
        for (int i = 0; i < 3; i++)
          if (got.t[i] !== want.t[i]) begin
            $display("%0t: t%0d expected %0d actual %0d", $time, 2-i,
                     want.t[i], got.t[i]);
            errors++;
          end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_quaternion_pose_to_matrix failed");
      $finish;
    end
  end

  // one pose transfer
  task automatic send_pose(pose_t p);
    frame_t f;
    trans_x_i <= p.tx; trans_y_i <= p.ty; trans_z_i <= p.tz;
    quat_w_i <= p.w; quat_x_i <= p.x; quat_y_i <= p.y; quat_z_i <= p.z;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    if (pose_to_frame(p, f)) expected_frames.push_back(f);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  // wait for all results plus latency, then write the scale
  task automatic drain_and_scale(logic [23:0] s);
    valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    scale_factor_i <= s;
    scale_factor_we_i <= 1'b1;
    @(negedge clk_i);
    scale_factor_we_i <= 1'b0;
    scale_reg = s;
  endtask

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    p.w = rand_part(); p.x = rand_part(); p.y = rand_part(); p.z = rand_part();
    if ($urandom_range(0, 40) == 0) {p.w, p.x, p.y, p.z} = '0;
    return p;
  endfunction

  task automatic test_directed();
    pose_t p;
    p = '{32'sd256, -32'sd256, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    send_pose(p);
    p = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send_pose(p);
    p = '{32'h80000000, 32'h7fffffff, 32'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    send_pose(p);
    // zero quaternion gives no result
    p = '{32'd5, 32'd6, 32'd7, 16'd0, 16'd0, 16'd0, 16'd0};
    send_pose(p);
    p = '{32'd1, 32'd2, 32'd3, 16'd0, 16'd1, 16'd0, 16'd0};
    send_pose(p);
    p = '{32'd1, 32'd2, 32'd3, 16'd0, 16'd0, 16'hffff, 16'd0};
    send_pose(p);
    p = '{32'd1, 32'd2, 32'd3, 16'd0, 16'd0, 16'd0, 16'h8000};
    send_pose(p);
    p = '{-32'sd1, 32'd0, 32'd0, 16'd1, 16'd1, 16'd1, 16'd1};
    send_pose(p);
    p = '{32'd0, 32'd0, 32'd0, 16'h5a82, 16'h5a82, 16'd0, 16'd0};
    send_pose(p);
    p = '{32'hffffff00, 32'd0, 32'd0, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};
    send_pose(p);
  endtask

  task automatic test_scale_extremes();
    drain_and_scale(24'hffffff);
    test_directed();
    drain_and_scale(24'h000000);
    test_directed();
    drain_and_scale(24'h000001);
    test_directed();
  endtask

  task automatic test_random(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 20)) begin
        send_pose(rand_pose());
        sent++;
      end
      if ($urandom_range(0, 2) == 0) sender_gap();
    end
  endtask

  task automatic test_no_stall_stream();
    stall_enable = 1'b0;
    repeat (100) send_pose(rand_pose());
    stall_enable = 1'b1;
  endtask

  initial begin
    scale_reg = 24'd65536;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_scale_extremes();
    drain_and_scale(24'd65536);
    test_random(400);
    drain_and_scale(24'($urandom));
    test_no_stall_stream();
    test_random(400);
    drain_and_scale(24'($urandom));
    test_random(300);
    valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0) $display("tb_quaternion_pose_to_matrix passed");
    else $display("tb_quaternion_pose_to_matrix failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/qpm_pkg.sv
src/qpm_div_cell.sv
src/qpm_front.sv
src/qpm_back.sv
src/quaternion_pose_to_matrix.sv
test/tb_quaternion_pose_to_matrix.sv
